[design/thd_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, holiday codes, months and the queue record of the holiday date block.
package thd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int KIND_W  = 3;
	localparam int NKIND   = 6;

	localparam logic [KIND_W-1:0] KIND_NEW_YEAR    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD_FRIDAY = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EASTER_MON  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LABOUR_DAY  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CHRISTMAS   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_BOXING_DAY  = 3'd5;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified year: both Easter dates and the set of holidays to emit.
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] gf_month;
		logic [DAY_W-1:0]   gf_day;
		logic [MONTH_W-1:0] em_month;
		logic [DAY_W-1:0]   em_day;
		logic [NKIND-1:0]   mask;
	} thd_rec_t;

endpackage

[design/thd_ifs.sv]
`timescale 1ns / 1ps
// Handshake channels for the year input and the holiday output.
interface thd_year_if;
	logic                       valid;
	logic                       ready;
	logic [thd_pkg::YEAR_W-1:0] year;

	modport source (output valid, output year, input ready);
	modport sink (input valid, input year, output ready);
endinterface

interface thd_hol_if;
	logic                        valid;
	logic                        ready;
	logic [thd_pkg::YEAR_W-1:0]  holiday_year;
	logic [thd_pkg::MONTH_W-1:0] holiday_month;
	logic [thd_pkg::DAY_W-1:0]   holiday_day;
	logic [thd_pkg::KIND_W-1:0]  holiday_kind;
	logic                        last_of_year;

	modport source (output valid, output holiday_year, output holiday_month,
		output holiday_day, output holiday_kind, output last_of_year, input ready);
	modport sink (input valid, input holiday_year, input holiday_month,
		input holiday_day, input holiday_kind, input last_of_year, output ready);
endinterface

[design/thd_front.sv]
`timescale 1ns / 1ps
// Nine-stage pipeline: computus and weekday checks, one classified year record out.
module thd_front (
	input  logic              clk,
	input  logic              arst_n,
	thd_year_if.sink          years,
	output thd_pkg::thd_rec_t rec,
	output logic              rec_valid,
	input  logic              rec_ready
);
	import thd_pkg::*;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	// stage registers
	logic [YEAR_W-1:0] y_s1, y_s2, y_s3, y_s4, y_s5, y_s6, y_s7, y_s8, y_s9;
	logic [7:0]  b_s2, b_s3, b_s4;
	logic [9:0]  q19_s2;
	logic [14:0] yj_s2, ym_s2;
	logic [7:0]  pj_s2, pm_s2;
	logic [4:0]  a_s3, a_s4, a_s5, a_s6, a_s7, a_s8;
	logic [6:0]  c_s3;
	logic [2:0]  f_s3;
	logic [14:0] xj_s3, xm_s3, x25_s3, x26_s3;
	logic [14:0] xj_s4, xm_s4, x25_s4, x26_s4;
	logic [11:0] qj_s4, qm_s4, q25_s4, q26_s4;
	logic [5:0]  d_s4, g_s4;
	logic [1:0]  e_s4, e_s5, e_s6, e_s7;
	logic [4:0]  i_s4, i_s5, i_s6, i_s7;
	logic [1:0]  k_s4, k_s5, k_s6, k_s7;
	logic [9:0]  t_s5, t_s6;
	logic [4:0]  qh_s6;
	logic [4:0]  h_s7, h_s8;
	logic [6:0]  x_s8;
	logic [3:0]  ql_s8;
	logic [7:0]  s_s9;
	logic [3:0]  wk_s5, wk_s6, wk_s7, wk_s8, wk_s9;

	// stage 1 logic
	logic [26:0] b_prod, pj_prod, pm_prod;
	logic [29:0] q19_prod;
	logic [14:0] yj_w, ym_w;
	// stage 2 logic
	logic [6:0]  c_w;
	logic [4:0]  a_w;
	logic [13:0] f_prod;
	logic [15:0] basej, basem;
	// stage 3 logic
	logic [7:0]  gsum;
	logic [15:0] g_prod;
	logic [29:0] qj_prod, qm_prod, q25_prod, q26_prod;
	// stage 4 logic
	logic [10:0] t_w;
	logic [2:0]  wj, wm, w25, w26;
	logic [3:0]  wk_w;
	// stage 5..8 logic
	logic [19:0] qh_prod;
	logic [4:0]  h_w;
	logic [7:0]  xs_w;
	logic [13:0] ql_prod;
	logic [2:0]  l_w;
	logic [8:0]  sm_w;
	logic        m_w;
	logic [7:0]  s_w;
	// stage 9 logic
	logic        em4;
	logic [3:0]  em_mon;
	logic [4:0]  ed;

	function automatic logic is_workday(input logic [2:0] w);
		return (w != 3'd0) && (w != 3'd6);
	endfunction

	assign adv = !vld_s9 || rec_ready;
	assign years.ready = adv;
	assign rec_valid = vld_s9;

	// y/100 and y/19 by reciprocal; weekday years are y+399 (January) and y+400
	assign b_prod   = 27'(y_s1) * 27'd5243;
	assign q19_prod = 30'(y_s1) * 30'd55189;
	assign yj_w     = 15'(y_s1) + 15'd399;
	assign ym_w     = 15'(y_s1) + 15'd400;
	assign pj_prod  = 27'(yj_w) * 27'd5243;
	assign pm_prod  = 27'(ym_w) * 27'd5243;

	assign c_w    = 7'(y_s2 - 14'(b_s2) * 14'd100);
	assign a_w    = 5'(y_s2 - 14'(q19_s2) * 14'd19);
	assign f_prod = (14'(b_s2) + 14'd8) * 14'd41;
	assign basej  = 16'(yj_s2) + 16'(yj_s2[14:2]) - 16'(pj_s2) + 16'(pj_s2[7:2]);
	assign basem  = 16'(ym_s2) + 16'(ym_s2[14:2]) - 16'(pm_s2) + 16'(pm_s2[7:2]);

	assign gsum     = b_s3 - 8'(f_s3) + 8'd1;
	assign g_prod   = 16'(gsum) * 16'd171;
	assign qj_prod  = 30'(xj_s3) * 30'd37450;
	assign qm_prod  = 30'(xm_s3) * 30'd37450;
	assign q25_prod = 30'(x25_s3) * 30'd37450;
	assign q26_prod = 30'(x26_s3) * 30'd37450;

	assign t_w  = 11'(a_s4) * 11'd19 + 11'(b_s4) - 11'(d_s4) - 11'(g_s4) + 11'd15;
	assign wj   = 3'(xj_s4 - 15'(qj_s4) * 15'd7);
	assign wm   = 3'(xm_s4 - 15'(qm_s4) * 15'd7);
	assign w25  = 3'(x25_s4 - 15'(q25_s4) * 15'd7);
	assign w26  = 3'(x26_s4 - 15'(q26_s4) * 15'd7);
	assign wk_w = {is_workday(w26), is_workday(w25), is_workday(wm), is_workday(wj)};

	assign qh_prod = 20'(t_s5) * 20'd547;
	assign h_w     = 5'(t_s6 - 10'(qh_s6) * 10'd30);
	assign xs_w    = 8'd32 + 8'(e_s7) * 8'd2 + 8'(i_s7) * 8'd2 - 8'(h_s7) - 8'(k_s7);
	assign ql_prod = 14'(xs_w[6:0]) * 14'd147;
	assign l_w     = 3'(x_s8 - 7'(ql_s8) * 7'd7);
	assign sm_w    = 9'(a_s8) + 9'(h_s8) * 9'd11 + 9'(l_w) * 9'd22;
	assign m_w     = sm_w >= 9'd451;
	assign s_w     = 8'(h_s8) + 8'(l_w) + 8'd114 - (m_w ? 8'd7 : 8'd0);

	// Easter falls in April once s reaches 124
	assign em4    = s_s9 >= 8'd124;
	assign em_mon = em4 ? MONTH_APR : MONTH_MAR;
	assign ed     = 5'(s_s9 - (em4 ? 8'd123 : 8'd92));

	always_comb begin
		rec.year = y_s9;
		if (ed > 5'd2) begin
			rec.gf_month = em_mon;
			rec.gf_day   = ed - 5'd2;
		end else begin
			// borrow from March
			rec.gf_month = em_mon - 4'd1;
			rec.gf_day   = ed + 5'd29;
		end
		if (!em4 && ed == 5'd31) begin
			rec.em_month = MONTH_APR;
			rec.em_day   = 5'd1;
		end else begin
			rec.em_month = em_mon;
			rec.em_day   = ed + 5'd1;
		end
		rec.mask = '0;
		rec.mask[KIND_NEW_YEAR]    = wk_s9[0];
		rec.mask[KIND_GOOD_FRIDAY] = 1'b1;
		rec.mask[KIND_EASTER_MON]  = 1'b1;
		rec.mask[KIND_LABOUR_DAY]  = wk_s9[1];
		rec.mask[KIND_CHRISTMAS]   = wk_s9[2];
		rec.mask[KIND_BOXING_DAY]  = wk_s9[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= years.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s1 <= years.year;

			y_s2   <= y_s1;
			b_s2   <= b_prod[26:19];
			q19_s2 <= q19_prod[29:20];
			yj_s2  <= yj_w;
			ym_s2  <= ym_w;
			pj_s2  <= pj_prod[26:19];
			pm_s2  <= pm_prod[26:19];

			y_s3   <= y_s2;
			a_s3   <= a_w;
			b_s3   <= b_s2;
			c_s3   <= c_w;
			f_s3   <= f_prod[12:10];
			xj_s3  <= 15'(basej + 16'd1);
			xm_s3  <= 15'(basem + 16'd1);
			x25_s3 <= 15'(basem + 16'd29);
			x26_s3 <= 15'(basem + 16'd30);

			y_s4   <= y_s3;
			a_s4   <= a_s3;
			b_s4   <= b_s3;
			d_s4   <= b_s3[7:2];
			e_s4   <= b_s3[1:0];
			g_s4   <= g_prod[14:9];
			i_s4   <= c_s3[6:2];
			k_s4   <= c_s3[1:0];
			xj_s4  <= xj_s3;
			xm_s4  <= xm_s3;
			x25_s4 <= x25_s3;
			x26_s4 <= x26_s3;
			qj_s4  <= qj_prod[29:18];
			qm_s4  <= qm_prod[29:18];
			q25_s4 <= q25_prod[29:18];
			q26_s4 <= q26_prod[29:18];

			y_s5  <= y_s4;
			a_s5  <= a_s4;
			e_s5  <= e_s4;
			i_s5  <= i_s4;
			k_s5  <= k_s4;
			t_s5  <= t_w[9:0];
			wk_s5 <= wk_w;

			y_s6  <= y_s5;
			a_s6  <= a_s5;
			e_s6  <= e_s5;
			i_s6  <= i_s5;
			k_s6  <= k_s5;
			t_s6  <= t_s5;
			qh_s6 <= qh_prod[18:14];
			wk_s6 <= wk_s5;

			y_s7  <= y_s6;
			a_s7  <= a_s6;
			e_s7  <= e_s6;
			i_s7  <= i_s6;
			k_s7  <= k_s6;
			h_s7  <= h_w;
			wk_s7 <= wk_s6;

			y_s8  <= y_s7;
			a_s8  <= a_s7;
			h_s8  <= h_s7;
			x_s8  <= xs_w[6:0];
			ql_s8 <= ql_prod[13:10];
			wk_s8 <= wk_s7;

			y_s9  <= y_s8;
			s_s9  <= s_w;
			wk_s9 <= wk_s8;
		end
	end

endmodule

[design/thd_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified year records between the front pipeline and the emitter.
module thd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  thd_pkg::thd_rec_t push_rec,
	output logic              push_ready,
	input  logic              pop,
	output thd_pkg::thd_rec_t head,
	output logic              head_valid
);
	import thd_pkg::*;

	thd_rec_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign push_ready = cnt_q != QCNT_W'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/thd_back.sv]
`timescale 1ns / 1ps
// Emitter: walks the head record's holiday set, one word per cycle into the output register while the output is ready.
module thd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  thd_pkg::thd_rec_t head,
	input  logic              head_valid,
	output logic              pop,
	thd_hol_if.source         holidays
);
	import thd_pkg::*;

	logic [NKIND-1:0]   done_q;
	logic               ovld_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic [KIND_W-1:0]  kind_q;
	logic               last_q;

	logic [NKIND-1:0]   pending, sel, rest;
	logic [KIND_W-1:0]  sel_kind;
	logic [MONTH_W-1:0] sel_month;
	logic [DAY_W-1:0]   sel_day;
	logic               load, emit, is_last;

	assign load    = !ovld_q || holidays.ready;
	assign emit    = load && head_valid;
	assign pending = head.mask & ~done_q;

	// take the earliest remaining holiday
	always_comb begin
		sel_kind = KIND_NEW_YEAR;
		for (int j = NKIND - 1; j >= 0; j--) begin
			if (pending[j]) begin
				sel_kind = KIND_W'(j);
			end
		end
	end

	assign sel     = NKIND'(1) << sel_kind;
	assign rest    = pending & ~sel;
	assign is_last = rest == '0;
	assign pop     = emit && is_last;

	always_comb begin
		case (sel_kind)
			KIND_NEW_YEAR: begin
				sel_month = MONTH_JAN;
				sel_day   = 5'd1;
			end
			KIND_GOOD_FRIDAY: begin
				sel_month = head.gf_month;
				sel_day   = head.gf_day;
			end
			KIND_EASTER_MON: begin
				sel_month = head.em_month;
				sel_day   = head.em_day;
			end
			KIND_LABOUR_DAY: begin
				sel_month = MONTH_MAY;
				sel_day   = 5'd1;
			end
			KIND_CHRISTMAS: begin
				sel_month = MONTH_DEC;
				sel_day   = 5'd25;
			end
			KIND_BOXING_DAY: begin
				sel_month = MONTH_DEC;
				sel_day   = 5'd26;
			end
			default: begin
				sel_month = MONTH_JAN;
				sel_day   = 5'd1;
			end
		endcase
	end

	assign holidays.valid         = ovld_q;
	assign holidays.holiday_year  = year_q;
	assign holidays.holiday_month = month_q;
	assign holidays.holiday_day   = day_q;
	assign holidays.holiday_kind  = kind_q;
	assign holidays.last_of_year  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			done_q <= '0;
		end else begin
			if (load) begin
				ovld_q <= head_valid;
			end
			if (pop) begin
				done_q <= '0;
			end else if (emit) begin
				done_q <= done_q | sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			year_q  <= head.year;
			month_q <= sel_month;
			day_q   <= sel_day;
			kind_q  <= sel_kind;
			last_q  <= is_last;
		end
	end

endmodule

[design/target_holiday_dates.sv]
`timescale 1ns / 1ps
// Top level of the holiday date block: front pipeline, record queue and emitter.
//
// Each year word yields two to six holiday words in date order, the last one
// flagged with last_of_year. The output port sets the pace: one holiday word
// leaves per cycle while the output is ready; a year holds the output until
// all its holidays (at most six) have left. Years enter a nine-stage pipeline
// that can take a new year every cycle while the four-entry record queue
// behind it has room, then pass the record queue and the output register.
// Either side may stall without blocking the other until the queue fills.
module target_holiday_dates (
	input logic       clk,
	input logic       arst_n,
	thd_year_if.sink  years,
	thd_hol_if.source holidays
);
	import thd_pkg::*;

	thd_rec_t front_rec, head;
	logic     front_valid, push_ready, head_valid, pop;

	thd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.years     (years),
		.rec       (front_rec),
		.rec_valid (front_valid),
		.rec_ready (push_ready)
	);

	thd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid && push_ready),
		.push_rec   (front_rec),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	thd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.holidays   (holidays)
	);

endmodule
